@@ rtl/core/idq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg
// shared constants, codes and controller-datapath command type
// ----------------------------------------------------------------------------
package idq_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = 4;
	localparam int DATA_W = 32;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP_FRONT = 2'd1,
		OP_POP_REAR = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} idq_cmd_t;

endpackage

@@ rtl/core/idq_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_req_if
// request channel: operation code and push data word
// ----------------------------------------------------------------------------
interface idq_req_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [31:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink (input valid, input op, input push_value, output ready);
endinterface

@@ rtl/core/idq_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_rsp_if
// response channel: status, removed word and element count
// ----------------------------------------------------------------------------
interface idq_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic signed [31:0] popped_value;
	logic [3:0] occupancy;

	modport source (output valid, output status, output popped_value, output occupancy,
		input ready);
	modport sink (input valid, input status, input popped_value, input occupancy,
		output ready);
endinterface

@@ rtl/core/idq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_ctrl
// handshake controller: takes one item, executes it, holds the result valid
// ----------------------------------------------------------------------------
module idq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output idq_pkg::idq_cmd_t cmd
);
	import idq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic rsp_valid_q;
	logic out_free;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/core/idq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_dp
// datapath: slot store, front and rear indices, result register
// ----------------------------------------------------------------------------
module idq_dp (
	input  logic clk,
	input  logic arst_n,
	input  idq_pkg::idq_cmd_t cmd,
	input  logic [1:0] op,
	input  logic signed [31:0] push_value,
	output logic [1:0] status,
	output logic signed [31:0] popped_value,
	output logic [3:0] occupancy
);
	import idq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [1:0] op_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic empty_q, empty_d;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [1:0] status_d;
	logic [DATA_W-1:0] popped_d;
	logic [OCC_W-1:0] occ_d;
	logic [1:0] status_q;
	logic [DATA_W-1:0] popped_q;
	logic [OCC_W-1:0] occ_q;

	// read address picked at accept time, pointers are stable then
	assign rd_addr = (op == OP_POP_FRONT) ? head_q : tail_q;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		wr_en = 1'b0;
		wr_addr = '0;
		status_d = ST_DONE;
		popped_d = '0;
		unique case (op_q)
			OP_PUSH: begin
				if (empty_q) begin
					head_d = '0;
					tail_d = '0;
					empty_d = 1'b0;
					wr_en = 1'b1;
					wr_addr = '0;
				end else if (tail_q == LAST_IDX) begin
					status_d = ST_FULL;
				end else begin
					tail_d = tail_q + 1'b1;
					wr_en = 1'b1;
					wr_addr = tail_q + 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty_q) begin
					status_d = ST_EMPTY;
				end else begin
					popped_d = rd_q;
					if (head_q >= tail_q) begin
						head_d = '0;
						tail_d = '0;
						empty_d = 1'b1;
					end else if (op_q == OP_POP_FRONT) begin
						head_d = head_q + 1'b1;
					end else begin
						tail_d = tail_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
		occ_d = empty_d ? '0 : OCC_W'(OCC_W'(tail_d) - OCC_W'(head_d) + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
			empty_q <= empty_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			val_q <= push_value;
			rd_q <= mem[rd_addr];
		end
		if (cmd.exec && wr_en)
			mem[wr_addr] <= val_q;
		if (cmd.exec) begin
			status_q <= status_d;
			popped_q <= popped_d;
			occ_q <= occ_d;
		end
	end

	assign status = status_q;
	assign popped_value = popped_q;
	assign occupancy = occ_q;
endmodule

@@ rtl/core/input_restricted_deque.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_restricted_deque
// deque over a linear store: push at the rear, pop at either end
// ----------------------------------------------------------------------------
// from item accept to result valid: the slot read is registered at accept, then execute registers the result
// one item at a time: the next accept waits until the previous item has executed
// a held result does not block the next accept; execution waits for it
// reset: async active low, indices to zero and store empty; slot contents
// are not cleared and need no clearing pass
module input_restricted_deque (
	input  logic clk,
	input  logic arst_n,
	idq_req_if.sink req,
	idq_rsp_if.source rsp
);
	import idq_pkg::*;

	// command bundle from the controller into the datapath
	idq_cmd_t cmd;

	// controller owns both handshakes and the result valid flag
	idq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath holds the slots, the indices and the result register
	idq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (req.op),
		.push_value   (req.push_value),
		.status       (rsp.status),
		.popped_value (rsp.popped_value),
		.occupancy    (rsp.occupancy)
	);
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks input_restricted_deque item by item against a local deque predictor;
// random gaps on both channels, a long response hold-off and drain pauses
// ----------------------------------------------------------------------------
module testbench;
	import idq_pkg::*;

	// one request item as queued for the driver
	typedef struct {
		op_t op;
		logic signed [DATA_W-1:0] value;
		int unsigned gap;      // idle cycles before the item is offered
		bit wait_drain;        // offered only once every result is back
	} deque_req_t;

	// one expected response item
	typedef struct {
		status_t status;
		logic signed [DATA_W-1:0] value;
		logic [OCC_W-1:0] occupancy;
	} deque_rsp_t;

	logic clk;
	logic arst_n;

	idq_req_if req_ch();
	idq_rsp_if rsp_ch();

	input_restricted_deque i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	deque_req_t pending_items[$];
	deque_rsp_t expected_rsps[$];

	// predictor copy of the deque
	logic [DATA_W-1:0] shadow_slots [DEPTH];
	logic [IDX_W-1:0] shadow_head = '0;
	logic [IDX_W-1:0] shadow_tail = '0;
	bit shadow_empty = 1'b1;

	int unsigned errors = 0;
	int unsigned n_items = 0;
	int unsigned n_stored = 0;
	int unsigned n_full = 0;
	int unsigned n_popped = 0;
	int unsigned n_empty = 0;
	int unsigned n_reclaim = 0;
	int unsigned n_unused = 0;

	// driver state
	deque_req_t staged_item;
	bit staged = 1'b0;
	int unsigned gap_left = 0;
	int in_flight = 0;

	// receiver state
	int unsigned rsp_taken = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit hold_done = 1'b0;
	int unsigned rx_cycle = 0;

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		else
			return $urandom_range(60, 20);
	endfunction

	// elements held: tail - head + 1 while anything is stored
	function automatic logic [OCC_W-1:0] held_count();
		if (shadow_empty)
			return '0;
		return {1'b0, shadow_tail} - {1'b0, shadow_head} + 4'd1;
	endfunction

	// a word biased towards the extremes now and then
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_item(input op_t op, input logic signed [DATA_W-1:0] value,
		input int unsigned gap, input bit wait_drain);
		deque_req_t it;
		it.op = op;
		it.value = value;
		it.gap = gap;
		it.wait_drain = wait_drain;
		pending_items.push_back(it);
	endtask

	// work out the response for one accepted item and update the shadow deque
	task automatic predict_result(input op_t op, input logic [DATA_W-1:0] word);
		deque_rsp_t r;
		r.status = ST_DONE;
		r.value = '0;
		case (op)
			OP_PUSH: begin
				if (shadow_empty) begin
					// empty store: the word always lands in slot 0
					shadow_head = '0;
					shadow_tail = '0;
					shadow_empty = 1'b0;
					shadow_slots[0] = word;
					n_stored++;
				end else if (shadow_tail == LAST_IDX) begin
					// rear at the last slot: full, freed front slots do not count
					r.status = ST_FULL;
					n_full++;
				end else begin
					shadow_tail = shadow_tail + 1'b1;
					shadow_slots[shadow_tail] = word;
					n_stored++;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (shadow_empty) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					r.value = (op == OP_POP_FRONT) ? shadow_slots[shadow_head]
						: shadow_slots[shadow_tail];
					n_popped++;
					if (shadow_head == shadow_tail) begin
						// last element gone: both indices back to zero
						shadow_head = '0;
						shadow_tail = '0;
						shadow_empty = 1'b1;
						n_reclaim++;
					end else if (op == OP_POP_FRONT) begin
						shadow_head = shadow_head + 1'b1;
					end else begin
						shadow_tail = shadow_tail - 1'b1;
					end
				end
			end
			default: begin
				// unused code: no state change, occupancy reported as is
				n_unused++;
			end
		endcase
		r.occupancy = held_count();
		expected_rsps.push_back(r);
	endtask

	// clock, period 8 ns
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// reset asserted from the start and released once
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver: offers queued items, holds them while the block stalls
	always @(posedge clk) begin : drive_req
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				in_flight++;
			if (rsp_ch.valid && rsp_ch.ready)
				in_flight--;
			if (!req_ch.valid || req_ch.ready) begin
				// no item on offer any more, pick up the next one
				if (!staged && pending_items.size() > 0) begin
					staged_item = pending_items.pop_front();
					staged = 1'b1;
					gap_left = staged_item.gap;
				end
				if (staged && gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (staged && !(staged_item.wait_drain && in_flight != 0)) begin
					req_ch.valid <= 1'b1;
					req_ch.op <= staged_item.op;
					req_ch.push_value <= staged_item.value;
					staged = 1'b0;
					n_items++;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, stretches with none, one long hold-off
	always @(posedge clk) begin : drive_rsp_ready
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rsp_ch.valid && rsp_ch.ready)
				rsp_taken++;
			if (!hold_done && rsp_taken >= 300) begin
				// long hold-off so the block fills and stalls its input
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				// no new stalls start in one window out of four
				if (((rx_cycle / 64) % 4) != 0 && $urandom_range(99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// monitor: predicts on request accept, checks on response accept
	always @(posedge clk) begin : monitor
		deque_rsp_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				predict_result(op_t'(req_ch.op), req_ch.push_value);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result status %0d value %0d occupancy %0d",
						$time, rsp_ch.status, rsp_ch.popped_value, rsp_ch.occupancy);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.popped_value !== want.value
						|| rsp_ch.occupancy !== want.occupancy) begin
						$display("%0t: mismatch expected status %0d value %0d occupancy %0d",
							$time, want.status, want.value, want.occupancy);
						$display("%0t:          actual   status %0d value %0d occupancy %0d",
							$time, rsp_ch.status, rsp_ch.popped_value, rsp_ch.occupancy);
						errors++;
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int unsigned n_rand;
		int unsigned phase_len;
		int unsigned push_pct;
		int unsigned phase_idx;
		int unsigned r;
		bit burst;
		op_t op;

		req_ch.valid = 1'b0;
		req_ch.op = OP_NONE;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty pops and the unused code on an empty store
		add_item(OP_POP_FRONT, '0, 0, 1'b0);
		add_item(OP_POP_REAR, '1, 0, 1'b0);
		add_item(OP_NONE, 32'sh1234_5678, 0, 1'b0);
		// fill every slot with extreme words
		add_item(OP_PUSH, 32'sh7FFF_FFFF, 0, 1'b0);
		add_item(OP_PUSH, 32'sh8000_0000, 0, 1'b0);
		add_item(OP_PUSH, '0, 0, 1'b0);
		add_item(OP_PUSH, '1, 0, 1'b0);
		add_item(OP_PUSH, 32'sh5555_5555, 0, 1'b0);
		add_item(OP_PUSH, 32'shAAAA_AAAA, 0, 1'b0);
		add_item(OP_PUSH, 32'sh0000_0001, 0, 1'b0);
		add_item(OP_PUSH, $urandom, 0, 1'b0);
		// full, then still full after the front has moved on
		add_item(OP_PUSH, 32'sh0BAD_0BAD, 0, 1'b0);
		add_item(OP_POP_FRONT, '0, 0, 1'b0);
		add_item(OP_PUSH, 32'sh0BAD_0BAD, 0, 1'b0);
		add_item(OP_NONE, '0, 0, 1'b0);
		add_item(OP_POP_REAR, '0, 0, 1'b0);
		// drain from the front down to the last element, then pop it off the rear
		repeat (5) add_item(OP_POP_FRONT, '0, 0, 1'b0);
		add_item(OP_POP_REAR, '0, 0, 1'b0);
		add_item(OP_POP_FRONT, '0, 0, 1'b0);
		add_item(OP_PUSH, 32'sh0F0F_0F0F, 0, 1'b0);

		// random: phases that lean towards filling, draining or a mix
		n_rand = 0;
		phase_idx = 0;
		while (n_rand < 900) begin
			phase_len = $urandom_range(40, 8);
			case ($urandom_range(2))
				0: push_pct = 78;
				1: push_pct = 25;
				default: push_pct = 52;
			endcase
			burst = ($urandom_range(3) == 0);
			for (int i = 0; i < phase_len; i++) begin
				r = $urandom_range(99);
				if (r < 3)
					op = OP_NONE;
				else if (r < push_pct)
					op = OP_PUSH;
				else if ($urandom_range(1))
					op = OP_POP_FRONT;
				else
					op = OP_POP_REAR;
				// every sixth phase opens with a pause until all results are in
				add_item(op, pick_word(), burst ? 0 : pick_gap(),
					(i == 0) && (phase_idx % 6 == 5));
				if (op != OP_NONE)
					n_rand++;
			end
			phase_idx++;
		end

		// wait for the queue to empty and every result to come back
		@(posedge arst_n);
		while (pending_items.size() != 0 || staged || req_ch.valid
			|| expected_rsps.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);

		$display("%0d items: %0d words stored, %0d pushes refused as full, %0d unused codes",
			n_items, n_stored, n_full, n_unused);
		$display("%0d words popped, %0d pops on an empty store, store emptied %0d times",
			n_popped, n_empty, n_reclaim);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", expected_rsps.size());
		$display("testbench NOT OK");
		$finish;
	end

endmodule
